// ===== hdl/vector_speed_slew_limiter_assert.svh =====
// assertion macros for the speed slew limiter checker
`ifndef VECTOR_SPEED_SLEW_LIMITER_ASSERT_SVH
`define VECTOR_SPEED_SLEW_LIMITER_ASSERT_SVH

// condition in one cycle implies the expression in the same cycle
`define VSSL_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("vssl: assertion failed");

// condition in one cycle implies the expression in the next cycle
`define VSSL_ASSERT_NXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("vssl: assertion failed");

`endif

// ===== hdl/vssl_pkg.sv =====
package vssl_pkg;

    // request types
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_AUTO   = 2'd1;
    localparam logic [1:0] REQ_MANUAL = 2'd2;
    localparam logic [1:0] REQ_MODE   = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ALWAYS = 1'd1;

    localparam int STEP_W = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;

    // control and status of the shared root / divide unit
    typedef struct packed {
        logic load;
        logic is_div;
    } t_rd_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rd_stat;

endpackage

// ===== hdl/vssl_if.sv =====
interface vssl_in_if #(
    parameter int VEL_WIDTH = 16
) ();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic signed [VEL_WIDTH-1:0] vel_x;
    logic signed [VEL_WIDTH-1:0] vel_y;
    logic signed [VEL_WIDTH-1:0] yaw_rate;
    logic                        allow_auto;

    modport source (
        output valid, req_type, vel_x, vel_y, yaw_rate, allow_auto,
        input  ready
    );
    modport sink (
        input  valid, req_type, vel_x, vel_y, yaw_rate, allow_auto,
        output ready
    );
endinterface

interface vssl_out_if #(
    parameter int VEL_WIDTH = 16
) ();
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] out_x;
    logic signed [VEL_WIDTH-1:0] out_y;
    logic signed [VEL_WIDTH-1:0] out_yaw;

    modport source (
        output valid, out_x, out_y, out_yaw,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_yaw,
        output ready
    );
endinterface

// ===== hdl/vssl_rdiv.sv =====
// shared restoring unit: integer square root or division, one digit a cycle
module vssl_rdiv
    import vssl_pkg::*;
#(
    parameter int W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_rd_ctl        i_ctl,
    input  logic [2*W:0]   i_num,
    input  logic [W:0]     i_den,
    output t_rd_stat       o_stat,
    output logic [W-1:0]   o_res,
    output logic [W+1:0]   o_rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_is_div;
    logic [W:0]       r_den;
    logic [2*W-1:0]   r_src;
    logic [W+1:0]     r_rem;
    logic [W-1:0]     r_res;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W+3:0]     shifted;
    logic [W+3:0]     trial;
    logic [W+3:0]     diff;
    logic             ge;
    logic [W+1:0]     n_rem;
    logic [W-1:0]     n_res;

    always_comb begin
        if (r_is_div) begin
            shifted = {1'b0, r_rem, r_src[2*W-1]};
            trial   = {3'b000, r_den};
        end else begin
            shifted = {r_rem, r_src[2*W-1:2*W-2]};
            trial   = {2'b00, r_res, 2'b01};
        end
        diff  = shifted - trial;
        ge    = (shifted >= trial);
        n_rem = ge ? diff[W+1:0] : shifted[W+1:0];
        n_res = {r_res[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_is_div <= i_ctl.is_div;
            r_den    <= i_den;
            r_res    <= '0;
            if (i_ctl.is_div) begin
                r_rem <= {1'b0, i_num[2*W:W]};
                r_src <= {i_num[W-1:0], {W{1'b0}}};
            end else begin
                r_rem <= '0;
                r_src <= i_num[2*W-1:0];
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_src <= r_is_div ? {r_src[2*W-2:0], 1'b0} : {r_src[2*W-3:0], 2'b00};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_res;
    assign o_rem       = r_rem;

endmodule

// ===== hdl/vector_speed_slew_limiter.sv =====
// a tick takes the square roots of the held command and the previous output, clamps the speed
//   step, then divides for each output component; a zero held command skips the divisions
// work runs through the shared root / divide unit; a new request is taken only while idle, so
//   a tick finishes before the next is accepted; a stalled result holds the input off
// reset: synchronous, active low; held command and previous output zero, auto mode clear,
//   max speed step 10
module vector_speed_slew_limiter
    import vssl_pkg::*;
#(
    parameter int VEL_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vssl_in_if.sink               i_req,
    vssl_out_if.source            o_res
);

    localparam int W = VEL_WIDTH;

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SQ_A      = 4'd1;  // square of x component
    localparam logic [3:0] ST_SQ_B      = 4'd2;  // square of y component
    localparam logic [3:0] ST_SUM       = 4'd3;  // start square root
    localparam logic [3:0] ST_SQRT_WAIT = 4'd4;
    localparam logic [3:0] ST_CLAMP     = 4'd5;
    localparam logic [3:0] ST_MUL       = 4'd6;  // speed times |component|
    localparam logic [3:0] ST_DIV_GO    = 4'd7;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    // state
    logic [3:0]          r_state;
    logic                r_pass;       // 0: held / x, 1: previous / y
    logic                r_auto_mode;
    logic [STEP_W-1:0]   r_max_step;
    logic signed [W-1:0] r_held_x;
    logic signed [W-1:0] r_held_y;
    logic signed [W-1:0] r_held_yaw;
    logic signed [W-1:0] r_prev_x;
    logic signed [W-1:0] r_prev_y;

    // datapath
    logic [2*W-1:0]      r_prod;
    logic [2*W-1:0]      r_acc;
    logic [W-1:0]        r_cur;
    logic [W-1:0]        r_last;
    logic [W-1:0]        r_speed;
    logic [W-1:0]        r_nx;
    logic [W-1:0]        r_ny;

    // output register
    logic                r_ov;
    logic [W-1:0]        r_out_x;
    logic [W-1:0]        r_out_y;
    logic [W-1:0]        r_out_yaw;

    logic                in_acc;
    logic                out_free;
    logic signed [W-1:0] comp;
    logic [W-1:0]        abs_c;
    logic [W-1:0]        mul_a;
    logic [2*W-1:0]      n_prod;
    logic [W-1:0]        root;
    logic [W+15:0]       cur_e;
    logic [W+15:0]       last_e;
    logic [W+15:0]       step_e;
    logic [W+15:0]       up_e;
    logic [W+15:0]       dn_e;
    logic [W-1:0]        n_speed;
    logic [W-1:0]        speed_sat;
    logic [W-1:0]        quo_sat;

    t_rd_ctl             rd_ctl;
    t_rd_stat            rd_stat;
    logic [2*W:0]        rd_num;
    logic [W:0]          rd_den;
    logic [W-1:0]        rd_res;
    logic [W+1:0]        rd_rem;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    // output register can take a new result when empty or being drained
    assign out_free    = !r_ov || o_res.ready;

    // component that feeds the multiplier or sets the quotient sign in this step
    always_comb begin
        if ((r_state == ST_MUL) || (r_state == ST_DIV_WAIT)) begin
            comp = r_pass ? r_held_y : r_held_x;
        end else if (r_state == ST_SQ_B) begin
            comp = r_pass ? r_prev_y : r_held_y;
        end else begin
            comp = r_pass ? r_prev_x : r_held_x;
        end
        // most negative value maps to its magnitude as an unsigned number
        abs_c  = comp[W-1] ? (~comp + 1'b1) : comp;
        mul_a  = (r_state == ST_MUL) ? r_speed : abs_c;
        n_prod = mul_a * abs_c;
    end

    // square root rounded to nearest, remainder above root rounds up
    assign root = rd_res + W'(rd_rem > {2'b00, rd_res});

    // magnitude step limit, extended so any step width compares safely
    always_comb begin
        cur_e  = {16'd0, r_cur};
        last_e = {16'd0, r_last};
        step_e = {{W{1'b0}}, r_max_step};
        up_e   = last_e + step_e;
        dn_e   = last_e - step_e;
        if (r_cur > r_last) begin
            n_speed = ((cur_e - last_e) > step_e) ? up_e[W-1:0] : r_cur;
        end else begin
            n_speed = ((last_e - cur_e) > step_e) ? dn_e[W-1:0] : r_cur;
        end
    end

    assign speed_sat = (r_speed > POS_MAX) ? POS_MAX : r_speed;

    // signed saturation of the scaled magnitude
    always_comb begin
        if (comp[W-1]) begin
            quo_sat = (rd_res > NEG_MIN) ? NEG_MIN : (~rd_res + 1'b1);
        end else begin
            quo_sat = (rd_res > POS_MAX) ? POS_MAX : rd_res;
        end
    end

    // shared unit requests: square root of x^2+y^2, or rounded division
    // (2*speed*|c| + cur) / (2*cur)
    always_comb begin
        rd_ctl.load   = (r_state == ST_SUM) || (r_state == ST_DIV_GO);
        rd_ctl.is_div = (r_state == ST_DIV_GO);
        if (r_state == ST_DIV_GO) begin
            rd_num = {r_prod, 1'b0} + {{(W+1){1'b0}}, r_cur};
        end else begin
            rd_num = {1'b0, r_acc + r_prod};
        end
        rd_den = {r_cur, 1'b0};
    end

    vssl_rdiv #(
        .W(W)
    ) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rd_ctl),
        .i_num   (rd_num),
        .i_den   (rd_den),
        .o_stat  (rd_stat),
        .o_res   (rd_res),
        .o_rem   (rd_rem)
    );

    // control: sequencer, mode flag, configuration, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_auto_mode <= 1'b0;
            r_max_step  <= STEP_RESET;
            r_ov        <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_held_yaw  <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            // output register loads at the end of tick work, else empties when taken
            if ((r_state == ST_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            // config writes are to come only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MAX_STEP) begin
                    r_max_step <= i_cfg_data[STEP_W-1:0];
                end
                if (i_cfg_idx == REG_AUTO_ALWAYS) begin
                    r_auto_mode <= i_cfg_data[0];
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_req.req_type)
                            REQ_TICK: begin
                                r_pass  <= 1'b0;
                                r_state <= ST_SQ_A;
                            end
                            REQ_AUTO, REQ_MANUAL: begin
                                // only the source selected by the mode flag is kept
                                if ((i_req.req_type == REQ_AUTO) == r_auto_mode) begin
                                    r_held_x   <= i_req.vel_x;
                                    r_held_y   <= i_req.vel_y;
                                    r_held_yaw <= i_req.yaw_rate;
                                end
                            end
                            default: begin
                                r_auto_mode <= i_req.allow_auto;
                            end
                        endcase
                    end
                end
                ST_SQ_A: r_state <= ST_SQ_B;
                ST_SQ_B: r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_SQRT_WAIT;
                ST_SQRT_WAIT: begin
                    if (rd_stat.done) begin
                        if (r_pass) begin
                            r_state <= ST_CLAMP;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= ST_SQ_A;
                        end
                    end
                end
                ST_CLAMP: begin
                    r_pass <= 1'b0;
                    // zero held vector points along +x, skip the divisions
                    r_state <= (r_cur == '0) ? ST_DONE : ST_MUL;
                end
                ST_MUL:    r_state <= ST_DIV_GO;
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (rd_stat.done) begin
                        if (r_pass) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_DONE: begin
                    // result moves to the output register and becomes the new previous output
                    if (out_free) begin
                        if (r_cur == '0) begin
                            r_prev_x <= speed_sat;
                            r_prev_y <= '0;
                        end else begin
                            r_prev_x <= r_nx;
                            r_prev_y <= r_ny;
                        end
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SQ_A) || (r_state == ST_SQ_B) || (r_state == ST_MUL)) begin
            r_prod <= n_prod;
        end
        if (r_state == ST_SQ_B) begin
            r_acc <= r_prod;
        end
        if ((r_state == ST_SQRT_WAIT) && rd_stat.done) begin
            if (r_pass) begin
                r_last <= root;
            end else begin
                r_cur <= root;
            end
        end
        if (r_state == ST_CLAMP) begin
            r_speed <= n_speed;
        end
        if ((r_state == ST_DIV_WAIT) && rd_stat.done) begin
            if (r_pass) begin
                r_ny <= quo_sat;
            end else begin
                r_nx <= quo_sat;
            end
        end
        if ((r_state == ST_DONE) && out_free) begin
            if (r_cur == '0) begin
                r_out_x <= speed_sat;
                r_out_y <= '0;
            end else begin
                r_out_x <= r_nx;
                r_out_y <= r_ny;
            end
            r_out_yaw <= r_held_yaw;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.out_x   = r_out_x;
    assign o_res.out_y   = r_out_y;
    assign o_res.out_yaw = r_out_yaw;

endmodule

// ===== hdl/vssl_chk.sv =====
`include "vector_speed_slew_limiter_assert.svh"

module vssl_chk
    import vssl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_type,
    input logic       i_out_valid,
    input logic       i_out_ready
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a result waits until taken
    `VSSL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // a tick keeps the block busy
    `VSSL_ASSERT_NXT(a_tick_busy, i_clk, i_rst_n, in_acc && (i_in_type == REQ_TICK), !i_in_ready)
    // commands and mode requests make no result
    `VSSL_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, in_acc && (i_in_type != REQ_TICK) && !i_out_valid, !i_out_valid)
    // a new result only appears at the end of tick work
    `VSSL_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind vector_speed_slew_limiter vssl_chk u_vssl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_type   (i_req.req_type),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);
